@@ hdl/atf_pkg.sv @@
// Shared types and constants for the ar archive timestamp filter.
// No dependencies; used by atf_parser and ar_archive_timestamp_filter_unit.
`default_nettype none
package atf_pkg;

  localparam int SIZE_BITS = 34;
  localparam int SIG_LEN   = 8;
  localparam int REP_BITS  = $clog2(SIG_LEN);

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
    8'h21, 8'h3c, 8'h61, 8'h72, 8'h63, 8'h68, 8'h3e, 8'h0a
  };

  localparam logic [5:0] HDR_TS_LO   = 6'd16;
  localparam logic [5:0] HDR_TS_END  = 6'd28;
  localparam logic [5:0] HDR_SZ_LO   = 6'd48;
  localparam logic [5:0] HDR_SZ_END  = 6'd58;
  localparam logic [5:0] HDR_LAST    = 6'd59;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TRUNC_HDR  = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
  localparam logic [1:0] ST_TRUNC_DATA = 2'd3;

  typedef enum logic [2:0] {
    PH_SIG, PH_PASS, PH_HDR, PH_DATA, PH_PAD, PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    PS_SPACE, PS_SIGN, PS_DIGITS, PS_STOP
  } pstep_t;

  // one accepted byte turns into rep_cnt replayed signature words, then this word
  typedef struct packed {
    logic [REP_BITS-1:0] rep_cnt;
    logic [7:0]          data;
    logic                keep;
    logic                done;
    logic [1:0]          status;
  } run_t;

endpackage
`default_nettype wire

@@ hdl/atf_parser.sv @@
// Archive state machine: signature match, header walk, size parse, data count.
// Depends on atf_pkg; produces one run descriptor per stepped byte.
`default_nettype none
module atf_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data,
  input  wire logic          eod,
  input  wire logic          ar_en,
  output atf_pkg::run_t      desc
);
  import atf_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [3:0]           sig_idx_r, sig_idx_nxt;
  logic [5:0]           hdr_r, hdr_nxt;
  pstep_t               ps_r, ps_nxt;
  logic                 neg_r, neg_nxt;
  logic                 seen_r, seen_nxt;
  logic [SIZE_BITS-1:0] msize_r, msize_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]           err_r, err_nxt;

  logic                 sig_match, sig_full, bad, in_size, ts_byte;
  logic [SIZE_BITS-1:0] rem_dec;
  logic                 ws, dig, go;
  logic [SIZE_BITS+3:0] m10;
  logic                 over;
  pstep_t               ps_p;
  logic                 neg_p, seen_p, ovf_p;
  logic [SIZE_BITS-1:0] msize_p;
  logic [1:0]           st;

  assign sig_match = ar_en && !sig_idx_r[3] && (data == SIG_BYTES[sig_idx_r[2:0]]);
  assign sig_full  = (sig_idx_r[2:0] == 3'(SIG_LEN - 1));
  assign bad       = (err_r != ST_OK) || !seen_r || (neg_r && (msize_r != '0));
  assign in_size   = (hdr_r >= HDR_SZ_LO) && (hdr_r < HDR_SZ_END);
  assign ts_byte   = (hdr_r >= HDR_TS_LO) && (hdr_r < HDR_TS_END);
  assign rem_dec   = rem_r - SIZE_BITS'(1);

  assign ws  = (data == 8'h20) || ((data >= 8'h09) && (data <= 8'h0d));
  assign dig = (data >= 8'h30) && (data <= 8'h39);
  assign m10 = ({4'b0, msize_r} << 3) + ({4'b0, msize_r} << 1)
             + {{SIZE_BITS{1'b0}}, data[3:0]};
  assign over = m10 > {4'b0, SIZE_MAX};

  // stoll-style size digit handling
  always_comb begin
    ps_p    = ps_r;
    neg_p   = neg_r;
    seen_p  = seen_r;
    msize_p = msize_r;
    ovf_p   = 1'b0;
    go      = (ps_r == PS_SIGN) || (ps_r == PS_DIGITS);
    if (ps_r == PS_SPACE) begin
      if (ws) begin
        go = 1'b0;
      end else if ((data == 8'h2b) || (data == 8'h2d)) begin
        neg_p = (data == 8'h2d);
        ps_p  = PS_SIGN;
        go    = 1'b0;
      end else begin
        go = 1'b1;
      end
    end
    if (go) begin
      if (dig) begin
        seen_p = 1'b1;
        ps_p   = PS_DIGITS;
        if (over) begin
          msize_p = SIZE_MAX;
          ovf_p   = 1'b1;
        end else begin
          msize_p = m10[SIZE_BITS-1:0];
        end
      end else begin
        ps_p = PS_STOP;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    sig_idx_nxt = sig_idx_r;
    hdr_nxt     = hdr_r;
    ps_nxt      = ps_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    msize_nxt   = msize_r;
    rem_nxt     = rem_r;
    err_nxt     = err_r;
    case (phase_r)
      PH_SIG: begin
        if (sig_match) begin
          if (sig_full) begin
            phase_nxt = PH_HDR;
            hdr_nxt   = '0;
          end else begin
            sig_idx_nxt = sig_idx_r + 4'd1;
          end
        end else begin
          phase_nxt = PH_PASS;
        end
      end
      PH_PASS: begin
      end
      PH_HDR: begin
        if (hdr_r == '0) begin
          ps_nxt    = PS_SPACE;
          neg_nxt   = 1'b0;
          seen_nxt  = 1'b0;
          msize_nxt = '0;
        end
        if (in_size) begin
          ps_nxt    = ps_p;
          neg_nxt   = neg_p;
          seen_nxt  = seen_p;
          msize_nxt = msize_p;
          if (ovf_p) err_nxt = ST_BAD_SIZE;
        end
        if (hdr_r == HDR_LAST) begin
          hdr_nxt = '0;
          if (bad) begin
            err_nxt   = ST_BAD_SIZE;
            phase_nxt = PH_ERR;
          end else if (msize_r != '0) begin
            rem_nxt   = msize_r;
            phase_nxt = PH_DATA;
          end
        end else begin
          hdr_nxt = hdr_r + 6'd1;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = msize_r[0] ? PH_PAD : PH_HDR;
          hdr_nxt   = '0;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_HDR;
        hdr_nxt   = '0;
      end
      default: begin
      end
    endcase
    if (eod) begin
      phase_nxt   = PH_SIG;
      sig_idx_nxt = '0;
      hdr_nxt     = '0;
      ps_nxt      = PS_SPACE;
      neg_nxt     = 1'b0;
      seen_nxt    = 1'b0;
      msize_nxt   = '0;
      rem_nxt     = '0;
      err_nxt     = ST_OK;
    end
  end

  // descriptor for the output run
  always_comb begin
    desc.data    = data;
    desc.done    = eod;
    desc.keep    = 1'b1;
    desc.rep_cnt = '0;
    st           = ST_OK;
    case (phase_r)
      PH_SIG: begin
        if (sig_match && !sig_full && !eod) begin
          desc.keep = 1'b0;
        end else if (sig_match && sig_full) begin
          desc.keep = 1'b0;
        end else begin
          desc.rep_cnt = sig_idx_r[3] ? REP_BITS'(SIG_LEN - 1) : sig_idx_r[2:0];
        end
      end
      PH_PASS: begin
      end
      PH_HDR: begin
        desc.keep = !ts_byte;
        if (hdr_r == HDR_LAST) begin
          if (bad) st = ST_BAD_SIZE;
          else if (msize_r != '0) st = ST_TRUNC_DATA;
        end else begin
          st = ST_TRUNC_HDR;
        end
      end
      PH_DATA: begin
        if (rem_dec != '0) st = ST_TRUNC_DATA;
      end
      PH_PAD: begin
        desc.keep = 1'b0;
      end
      default: begin
        desc.keep = 1'b0;
        st        = err_r;
      end
    endcase
    desc.status = eod ? st : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      sig_idx_r <= '0;
      hdr_r     <= '0;
      ps_r      <= PS_SPACE;
      neg_r     <= 1'b0;
      seen_r    <= 1'b0;
      msize_r   <= '0;
      rem_r     <= '0;
      err_r     <= ST_OK;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sig_idx_r <= sig_idx_nxt;
      hdr_r     <= hdr_nxt;
      ps_r      <= ps_nxt;
      neg_r     <= neg_nxt;
      seen_r    <= seen_nxt;
      msize_r   <= msize_nxt;
      rem_r     <= rem_nxt;
      err_r     <= err_nxt;
    end
  end

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r <= HDR_LAST) else $error("header index past end");
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR) |-> (err_r == ST_BAD_SIZE)) else $error("error phase without code");
  a_data_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (rem_r != '0)) else $error("data phase with nothing left");

endmodule
`default_nettype wire

@@ hdl/ar_archive_timestamp_filter_unit.sv @@
// Top level of the ar archive timestamp filter: input register, parser, output run.
// Depends on atf_pkg and atf_parser.
// A byte passes through the input register and then the output run register before its result appears.
// Throughput: one byte per cycle while out_stall is low; a signature mismatch
// replays up to 7 stored signature words ahead of the current one, one word per
// cycle, while the next byte waits in the input register.
// Reset (rst_n low, synchronous): parser state cleared, both stages empty, ar mode on.
`default_nettype none
module ar_archive_timestamp_filter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_keep,
  output logic            out_run_last,
  output logic            out_stream_done,
  output logic [1:0]      out_status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);
  import atf_pkg::*;

  logic                in_vld_r, in_vld_nxt;
  logic [7:0]          in_byte_r;
  logic                in_eod_r;
  logic                ar_en_r;
  logic                run_vld_r, run_vld_nxt;
  run_t                run_r;
  run_t                desc;
  logic [REP_BITS-1:0] rep_idx_r, rep_idx_nxt;
  logic                at_last, finishing, move, accept;

  assign at_last   = (rep_idx_r == run_r.rep_cnt);
  assign finishing = run_vld_r && at_last && !out_stall;
  assign move      = in_vld_r && (!run_vld_r || finishing);
  assign in_stall  = in_vld_r && !move;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  atf_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .data  (in_byte_r),
    .eod   (in_eod_r),
    .ar_en (ar_en_r),
    .desc  (desc)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    run_vld_nxt = run_vld_r;
    rep_idx_nxt = rep_idx_r;
    if (accept) in_vld_nxt = 1'b1;
    else if (move) in_vld_nxt = 1'b0;
    if (move) begin
      run_vld_nxt = 1'b1;
      rep_idx_nxt = '0;
    end else if (finishing) begin
      run_vld_nxt = 1'b0;
    end else if (run_vld_r && !out_stall) begin
      rep_idx_nxt = rep_idx_r + REP_BITS'(1);
    end
  end

  assign out_valid       = run_vld_r;
  assign out_byte        = at_last ? run_r.data : SIG_BYTES[rep_idx_r];
  assign out_keep        = at_last ? run_r.keep : 1'b1;
  assign out_run_last    = at_last;
  assign out_stream_done = at_last && run_r.done;
  assign out_status      = at_last ? run_r.status : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      run_vld_r <= 1'b0;
      rep_idx_r <= '0;
      ar_en_r   <= 1'b1;
    end else begin
      in_vld_r  <= in_vld_nxt;
      run_vld_r <= run_vld_nxt;
      rep_idx_r <= rep_idx_nxt;
      if (cfg_valid && cfg_ready) ar_en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
      in_eod_r  <= in_end_of_data;
    end
    if (move) run_r <= desc;
  end

  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_vld_r |-> (rep_idx_r <= run_r.rep_cnt)) else $error("replay index past count");
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (run_vld_r && !at_last) |=> run_vld_r) else $error("run dropped before last word");
  a_replay_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (run_vld_r && !at_last) |-> (out_keep && !out_stream_done && (out_status == ST_OK)))
    else $error("replayed word with wrong flags");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (run_vld_r && out_stall) |=> (run_vld_r && $stable(rep_idx_r)))
    else $error("stalled run advanced");

endmodule
`default_nettype wire

@@ sim/ar_archive_timestamp_filter_unit_tb.sv @@
// Self-checking testbench for ar_archive_timestamp_filter_unit: a directed table, then
// random files (ar archives, broken signatures, noise), every result word checked in order.
// Depends on atf_pkg and the filter RTL.
`default_nettype none
module ar_archive_timestamp_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;
  localparam int HOLD_LEN     = 150;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ALPHA = 8'h61;
  localparam logic [7:0] CH_JUNK  = 8'h78;
  localparam logic [7:0] CH_GRAVE = 8'h60;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef struct packed {
    logic [7:0] data;
    logic       keep;
    logic       last;
    logic       done;
    logic [1:0] status;
  } filt_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    logic       typed;
    logic       keep;
    logic [1:0] status;
  } dir_row_t;

  localparam dir_row_t DIRECTED [23] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_OK},
    '{8'hff, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, ST_OK},
    '{8'h21, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h3c, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h61, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h63, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h68, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h3e, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h58, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h55, 1'b1, 1'b1, 1'b1, ST_OK},
    '{8'h21, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h3c, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h61, 1'b1, 1'b1, 1'b1, ST_OK},
    '{8'h21, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h3c, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h61, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h63, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h68, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h3e, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h0a, 1'b1, 1'b1, 1'b0, ST_OK}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       in_end_of_data = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_keep;
  logic       out_run_last;
  logic       out_stream_done;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  ar_archive_timestamp_filter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_data  (in_end_of_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_keep        (out_keep),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter model state
  logic                 ar_mode;
  phase_t               ph;
  logic [3:0]           sig_idx;
  logic [5:0]           hdr_idx;
  pstep_t               pstep;
  logic                 neg;
  logic                 digit_seen;
  logic [SIZE_BITS-1:0] msize;
  logic [SIZE_BITS-1:0] remaining;
  logic [1:0]           err;

  filt_word_t pending_words [$];
  logic [7:0] file_q [$];
  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  files_sent = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  calm = 1'b0;

  function automatic void clear_parser();
    ph         = PH_SIG;
    sig_idx    = '0;
    hdr_idx    = '0;
    pstep      = PS_SPACE;
    neg        = 1'b0;
    digit_seen = 1'b0;
    msize      = '0;
    remaining  = '0;
    err        = ST_OK;
  endfunction

  function automatic void queue_word(input logic [7:0] b, input logic keep);
    pending_words.push_back('{data: b, keep: keep, last: 1'b0, done: 1'b0, status: ST_OK});
  endfunction

  function automatic void filter_byte(input logic [7:0] b, input logic eod);
    logic [1:0]           st;
    logic [5:0]           h;
    logic                 ws;
    logic                 dig;
    logic                 taken;
    logic                 bad;
    logic [SIZE_BITS-1:0] d;
    filt_word_t           w;
    st = ST_OK;
    case (ph)
      PH_SIG: begin
        if (ar_mode && sig_idx < SIG_LEN && b == SIG_BYTES[sig_idx]) begin
          sig_idx = sig_idx + 1'b1;
          if (sig_idx == SIG_LEN) begin
            queue_word(b, 1'b0);
            ph = PH_HDR;
            hdr_idx = '0;
          end else if (eod) begin
            for (int i = 0; i + 1 < sig_idx; i++) queue_word(SIG_BYTES[i], 1'b1);
            queue_word(b, 1'b1);
          end else begin
            queue_word(b, 1'b0);
          end
        end else begin
          for (int i = 0; i < sig_idx && i < SIG_LEN - 1; i++) queue_word(SIG_BYTES[i], 1'b1);
          queue_word(b, 1'b1);
          ph = PH_PASS;
        end
      end
      PH_PASS: queue_word(b, 1'b1);
      PH_HDR: begin
        h = hdr_idx;
        queue_word(b, h < HDR_TS_LO || h >= HDR_TS_END);
        if (h == 0) begin
          pstep = PS_SPACE;
          neg = 1'b0;
          digit_seen = 1'b0;
          msize = '0;
        end
        if (h >= HDR_SZ_LO && h < HDR_SZ_END) begin
          ws = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
          dig = (b >= CH_ZERO && b <= CH_NINE);
          taken = 1'b0;
          if (pstep == PS_SPACE) begin
            if (ws) begin
              taken = 1'b1;
            end else begin
              if (b == CH_PLUS || b == CH_MINUS) begin
                neg = (b == CH_MINUS);
                taken = 1'b1;
              end
              pstep = PS_SIGN;
            end
          end
          if (!taken && (pstep == PS_SIGN || pstep == PS_DIGITS)) begin
            if (dig) begin
              d = b - CH_ZERO;
              digit_seen = 1'b1;
              pstep = PS_DIGITS;
              if (msize > (SIZE_MAX - d) / 10) begin
                msize = SIZE_MAX;
                err = ST_BAD_SIZE;
              end else begin
                msize = msize * 10 + d;
              end
            end else begin
              pstep = PS_STOP;
            end
          end
        end
        if (h >= HDR_LAST) begin
          bad = (err != ST_OK) || !digit_seen || (neg && msize != 0);
          hdr_idx = '0;
          if (bad) begin
            err = ST_BAD_SIZE;
            ph = PH_ERR;
            st = ST_BAD_SIZE;
          end else if (msize == 0) begin
            ph = PH_HDR;
          end else begin
            remaining = msize;
            ph = PH_DATA;
            st = ST_TRUNC_DATA;
          end
        end else begin
          hdr_idx = h + 1'b1;
          st = ST_TRUNC_HDR;
        end
      end
      PH_DATA: begin
        queue_word(b, 1'b1);
        remaining = remaining - 1'b1;
        if (remaining == 0) begin
          if (msize[0]) ph = PH_PAD;
          else ph = PH_HDR;
          hdr_idx = '0;
        end else begin
          st = ST_TRUNC_DATA;
        end
      end
      PH_PAD: begin
        queue_word(b, 1'b0);
        ph = PH_HDR;
        hdr_idx = '0;
      end
      default: begin
        queue_word(b, 1'b0);
        st = err;
      end
    endcase
    w = pending_words.pop_back();
    w.last = 1'b1;
    if (eod) begin
      w.done = 1'b1;
      w.status = st;
      clear_parser();
    end
    pending_words.push_back(w);
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (in_stall);
    filter_byte(b, eod);
    words_in++;
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ar_mode = mode;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic build_file(input bit force_ar);
    int         kind;
    int         n;
    int         members;
    int         sz;
    int         ndata;
    int         dpos;
    int         flen;
    bit         good;
    bit         huge;
    logic [7:0] b;
    logic [7:0] fld [10];
    string      s;
    file_q.delete();
    kind = force_ar ? 9 : $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
    end else if (kind < 4) begin
      // signature prefix, then a wrong byte
      n = $urandom_range(0, SIG_LEN - 1);
      for (int i = 0; i < n; i++) file_q.push_back(SIG_BYTES[i]);
      b = 8'($urandom);
      if (b == SIG_BYTES[n]) b = b ^ 8'h80;
      file_q.push_back(b);
      repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
    end else begin
      foreach (SIG_BYTES[i]) file_q.push_back(SIG_BYTES[i]);
      members = $urandom_range(0, 2);
      huge = 1'b0;
      for (int m = 0; m < members && !huge; m++) begin
        repeat (HDR_SZ_LO) file_q.push_back(8'($urandom));
        foreach (fld[i]) fld[i] = CH_SPACE;
        sz = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 25) : $urandom_range(0, 5);
        good = 1'b1;
        dpos = 0;
        case ($urandom_range(0, 9))
          4: begin
            dpos = $urandom_range(1, 4);
            for (int i = 0; i < dpos; i++)
              fld[i] = ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
          end
          5: begin
            fld[0] = CH_PLUS;
            dpos = 1;
          end
          6: begin
            fld[0] = CH_MINUS;
            dpos = 1;
            sz = 0;
          end
          7: begin
            good = 1'b0;
            dpos = -1;
            case ($urandom_range(0, 3))
              1: fld[0] = CH_PLUS;
              2: fld[0] = CH_MINUS;
              3: fld[0] = CH_ALPHA;
              default: ;
            endcase
          end
          8: begin
            fld[0] = CH_MINUS;
            dpos = 1;
            sz = $urandom_range(1, 9);
            good = 1'b0;
          end
          9: begin
            dpos = -1;
            if ($urandom_range(0, 1) == 0) begin
              foreach (fld[i]) fld[i] = CH_NINE;
              huge = 1'b1;
            end else begin
              foreach (fld[i]) fld[i] = CH_ZERO;
              sz = 0;
            end
          end
          default: ;
        endcase
        if (dpos >= 0) begin
          s = $sformatf("%0d", sz);
          for (int i = 0; i < s.len(); i++) fld[dpos + i] = s[i];
          if (dpos + s.len() < 10 && $urandom_range(0, 5) == 0) fld[dpos + s.len()] = CH_JUNK;
        end
        foreach (fld[i]) file_q.push_back(fld[i]);
        file_q.push_back(CH_GRAVE);
        file_q.push_back(CH_NL);
        ndata = huge ? 4 : good ? sz + sz % 2 : $urandom_range(0, 3);
        repeat (ndata) file_q.push_back(8'($urandom));
      end
      case (force_ar ? 0 : $urandom_range(0, 9))
        5, 6: flen = $urandom_range(1, file_q.size());
        7: flen = SIG_LEN + HDR_LAST + 1;
        8: flen = file_q.size() - 1;
        default: flen = file_q.size();
      endcase
      while (file_q.size() > flen) void'(file_q.pop_back());
    end
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic run_files(input int budget);
    int start;
    start = words_in;
    while (words_in - start < budget) begin
      calm = ($urandom_range(0, 3) == 0);
      build_file(1'b0);
      send_file();
    end
    calm = 1'b0;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    filt_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %0h", $time, out_byte);
        errors++;
      end else begin
        w = pending_words.pop_front();
        check_field("out_byte", w.data, out_byte);
        check_field("out_keep", w.keep, out_keep);
        check_field("out_run_last", w.last, out_run_last);
        check_field("out_stream_done", w.done, out_stream_done);
        check_field("out_status", w.status, out_status);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycle_count,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    filt_word_t w;
    ar_mode = 1'b1;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b1);

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].b, DIRECTED[i].eod);
      if (DIRECTED[i].typed) begin
        w = pending_words.pop_back();
        w.keep = DIRECTED[i].keep;
        w.status = DIRECTED[i].status;
        pending_words.push_back(w);
      end
    end
    wait_idle();

    run_files(40);
    wait_idle();
    write_mode(1'b0);
    run_files(10);
    wait_idle();
    write_mode(1'b1);

    // fill the pipe against a stalled receiver, then let it drain fully
    calm = 1'b1;
    hold_cycles = HOLD_LEN;
    build_file(1'b1);
    send_file();
    calm = 1'b0;
    wait_idle();

    $display("Sent %0d files (%0d bytes), checked %0d result words.", files_sent, words_in,
             words_out);
    $display("Covered signature replay, header timestamps, size parsing, pads, ar mode on/off.");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/atf_pkg.sv
hdl/atf_parser.sv
hdl/ar_archive_timestamp_filter_unit.sv
sim/ar_archive_timestamp_filter_unit_tb.sv
